/* hdl/plob_pkg.sv */
// Package for the price-level order book matcher.
// Holds the sizing constants, the sequencer state type and the shared unit's command codes.
// It has no dependencies.
package plob_pkg;

    localparam int PRICE_LEVELS   = 1024;
    localparam int LEVEL_QTY_BITS = 32;

    localparam int IDX_W     = $clog2(PRICE_LEVELS);
    localparam int PRICE_W   = 20;
    localparam int ORD_QTY_W = 16;
    localparam int FILLS_W   = 11;
    localparam int TRADES_W  = 64;
    localparam int SUM_W     = ((LEVEL_QTY_BITS > ORD_QTY_W) ? LEVEL_QTY_BITS : ORD_QTY_W) + 1;

    localparam logic [SUM_W-1:0]   LEVEL_MAX  = (SUM_W'(1) << LEVEL_QTY_BITS) - SUM_W'(1);
    localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(PRICE_LEVELS - 1);
    localparam logic [PRICE_W-1:0] LEVELS_PRC = PRICE_W'(PRICE_LEVELS);
    localparam logic [FILLS_W-1:0] FILLS_MAX  = '1;

    typedef logic [LEVEL_QTY_BITS-1:0] t_qty;
    typedef logic [IDX_W-1:0]          t_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_CHECK,
        ST_MATCH,
        ST_BID_STEP,
        ST_BID_RD,
        ST_BID_CHK,
        ST_ASK_STEP,
        ST_ASK_RD,
        ST_ASK_CHK,
        ST_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD_SAT,
        ALU_SUB_ABS
    } t_alu_cmd;

endpackage

/* hdl/plob_order_if.sv */
// Request channels of the order book matcher: the order channel and the result channel.
// Depends on plob_pkg for the field widths.
interface plob_order_if;
    logic                              valid;
    logic                              ready;
    logic                              buy_side;
    logic [plob_pkg::PRICE_W-1:0]      price;
    logic [plob_pkg::ORD_QTY_W-1:0]    quantity;

    modport source (output valid, buy_side, price, quantity, input ready);
    modport sink   (input valid, buy_side, price, quantity, output ready);
endinterface

interface plob_result_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic [plob_pkg::FILLS_W-1:0]      fills_in_order;
    logic [plob_pkg::TRADES_W-1:0]     total_trades;
    logic                              bid_present;
    logic [plob_pkg::PRICE_W-1:0]      best_bid_price;
    logic                              ask_present;
    logic [plob_pkg::PRICE_W-1:0]      best_ask_price;

    modport source (output valid, status, fills_in_order, total_trades, bid_present,
                    best_bid_price, ask_present, best_ask_price, input ready);
    modport sink   (input valid, status, fills_in_order, total_trades, bid_present,
                    best_bid_price, ask_present, best_ask_price, output ready);
endinterface

/* hdl/plob_alu.sv */
// Shared quantity unit: saturating level add and absolute difference with compare.
// Depends on plob_pkg.
module plob_alu (
    input  plob_pkg::t_alu_cmd              i_cmd,
    input  plob_pkg::t_qty                  i_a,
    input  plob_pkg::t_qty                  i_b,
    input  logic [plob_pkg::ORD_QTY_W-1:0]  i_q,
    output plob_pkg::t_qty                  o_res,
    output logic                            o_a_lt_b
);
    logic [plob_pkg::SUM_W-1:0] sum;

    always_comb begin
        sum      = plob_pkg::SUM_W'(i_a) + plob_pkg::SUM_W'(i_q);
        o_a_lt_b = (i_a < i_b);
        case (i_cmd)
            plob_pkg::ALU_ADD_SAT: begin
                o_res = (sum > plob_pkg::LEVEL_MAX) ? plob_pkg::LEVEL_MAX[plob_pkg::LEVEL_QTY_BITS-1:0]
                                                    : sum[plob_pkg::LEVEL_QTY_BITS-1:0];
            end
            plob_pkg::ALU_SUB_ABS: begin
                o_res = o_a_lt_b ? (i_b - i_a) : (i_a - i_b);
            end
            default: begin
                o_res = '0;
            end
        endcase
    end
endmodule

/* hdl/price_level_order_book_matcher_core.sv */
// Price-level order book matcher, top level. Uses plob_pkg, the channel interfaces and plob_alu.
// After reset a clearing pass zeroes both level memories, one entry per cycle, with the order
// channel not ready. A rejected order goes straight to its result. An accepted order is added
// to its level and crossed trade by trade, each emptied best level searched past level by level;
// each result enters the result register once an earlier one is taken; the next request follows.
// Reset is synchronous and active low; it clears the book and count.
module price_level_order_book_matcher_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [plob_pkg::PRICE_W-1:0]  i_cfg_wdata,
    plob_order_if.sink                    i_order,
    plob_result_if.source                 o_result
);
    // Aggregated quantity per price level. A level is occupied exactly when its
    // quantity is nonzero, so no separate occupancy map is kept.
    plob_pkg::t_qty bid_mem [plob_pkg::PRICE_LEVELS];
    plob_pkg::t_qty ask_mem [plob_pkg::PRICE_LEVELS];

    plob_pkg::t_state r_state, n_state;

    logic [plob_pkg::PRICE_W-1:0]   r_price_base;
    plob_pkg::t_idx                 r_clr, n_clr;
    logic                           r_buy, n_buy;
    logic [plob_pkg::ORD_QTY_W-1:0] r_qty, n_qty;
    plob_pkg::t_idx                 r_idx, n_idx;
    plob_pkg::t_idx                 r_best_bid, n_best_bid;
    plob_pkg::t_idx                 r_best_ask, n_best_ask;
    logic                           r_bid_pres, n_bid_pres;
    logic                           r_ask_pres, n_ask_pres;
    logic                           r_scan_ask, n_scan_ask;
    logic                           r_status, n_status;
    logic [plob_pkg::FILLS_W-1:0]   r_fills, n_fills;
    logic [plob_pkg::TRADES_W-1:0]  r_trades, n_trades;
    plob_pkg::t_qty                 r_bid_rd, r_ask_rd;

    // Result register; the result stays here until the sink takes it.
    logic                           r_out_valid, n_out_valid;
    logic                           r_o_status, n_o_status;
    logic [plob_pkg::FILLS_W-1:0]   r_o_fills, n_o_fills;
    logic [plob_pkg::TRADES_W-1:0]  r_o_trades, n_o_trades;
    logic                           r_o_bpres, n_o_bpres;
    logic [plob_pkg::PRICE_W-1:0]   r_o_bprice, n_o_bprice;
    logic                           r_o_apres, n_o_apres;
    logic [plob_pkg::PRICE_W-1:0]   r_o_aprice, n_o_aprice;

    // Memory port controls.
    plob_pkg::t_idx bid_raddr, ask_raddr, bid_waddr, ask_waddr;
    logic           bid_we, ask_we;
    plob_pkg::t_qty bid_wdata, ask_wdata;

    // Shared unit.
    plob_pkg::t_alu_cmd alu_cmd;
    plob_pkg::t_qty     alu_a, alu_b, alu_res;
    logic               alu_lt;

    logic [plob_pkg::PRICE_W:0] win_diff;
    logic                       in_window;
    logic                       bid_empty;

    plob_alu u_alu (
        .i_cmd    (alu_cmd),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_q      (r_qty),
        .o_res    (alu_res),
        .o_a_lt_b (alu_lt)
    );

    // The window check works on the incoming request so that a rejected order
    // goes straight to its result.
    assign win_diff  = {1'b0, i_order.price} - {1'b0, r_price_base};
    assign in_window = !win_diff[plob_pkg::PRICE_W] &&
                       (win_diff[plob_pkg::PRICE_W-1:0] < plob_pkg::LEVELS_PRC);

    assign i_order.ready          = (r_state == plob_pkg::ST_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_o_status;
    assign o_result.fills_in_order = r_o_fills;
    assign o_result.total_trades   = r_o_trades;
    assign o_result.bid_present    = r_o_bpres;
    assign o_result.best_bid_price = r_o_bprice;
    assign o_result.ask_present    = r_o_apres;
    assign o_result.best_ask_price = r_o_aprice;

    // During a match the bid level empties when it was the smaller or the two were equal.
    assign bid_empty = alu_lt || (alu_res == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_price_base <= '0;
        end else if (i_cfg_we) begin
            r_price_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bid_rd <= bid_mem[bid_raddr];
        r_ask_rd <= ask_mem[ask_raddr];
        if (bid_we) begin
            bid_mem[bid_waddr] <= bid_wdata;
        end
        if (ask_we) begin
            ask_mem[ask_waddr] <= ask_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plob_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_bid_pres  <= 1'b0;
            r_ask_pres  <= 1'b0;
            r_trades    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_bid_pres  <= n_bid_pres;
            r_ask_pres  <= n_ask_pres;
            r_trades    <= n_trades;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buy      <= n_buy;
        r_qty      <= n_qty;
        r_idx      <= n_idx;
        r_best_bid <= n_best_bid;
        r_best_ask <= n_best_ask;
        r_scan_ask <= n_scan_ask;
        r_status   <= n_status;
        r_fills    <= n_fills;
        r_o_status <= n_o_status;
        r_o_fills  <= n_o_fills;
        r_o_trades <= n_o_trades;
        r_o_bpres  <= n_o_bpres;
        r_o_bprice <= n_o_bprice;
        r_o_apres  <= n_o_apres;
        r_o_aprice <= n_o_aprice;
    end

    // Sequencer: next state, datapath updates and memory port controls.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_buy       = r_buy;
        n_qty       = r_qty;
        n_idx       = r_idx;
        n_best_bid  = r_best_bid;
        n_best_ask  = r_best_ask;
        n_bid_pres  = r_bid_pres;
        n_ask_pres  = r_ask_pres;
        n_scan_ask  = r_scan_ask;
        n_status    = r_status;
        n_fills     = r_fills;
        n_trades    = r_trades;
        n_out_valid = r_out_valid && !o_result.ready;
        n_o_status  = r_o_status;
        n_o_fills   = r_o_fills;
        n_o_trades  = r_o_trades;
        n_o_bpres   = r_o_bpres;
        n_o_bprice  = r_o_bprice;
        n_o_apres   = r_o_apres;
        n_o_aprice  = r_o_aprice;

        bid_raddr = (r_state == plob_pkg::ST_ADD_RD) ? r_idx : r_best_bid;
        ask_raddr = (r_state == plob_pkg::ST_ADD_RD) ? r_idx : r_best_ask;
        bid_waddr = r_best_bid;
        ask_waddr = r_best_ask;
        bid_we    = 1'b0;
        ask_we    = 1'b0;
        bid_wdata = '0;
        ask_wdata = '0;

        alu_cmd = plob_pkg::ALU_SUB_ABS;
        alu_a   = r_bid_rd;
        alu_b   = r_ask_rd;

        case (r_state)
            plob_pkg::ST_CLEAR: begin
                bid_we    = 1'b1;
                ask_we    = 1'b1;
                bid_waddr = r_clr;
                ask_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == plob_pkg::IDX_LAST) begin
                    n_state = plob_pkg::ST_IDLE;
                end
            end
            plob_pkg::ST_IDLE: begin
                if (i_order.valid) begin
                    n_buy   = i_order.buy_side;
                    n_qty   = i_order.quantity;
                    n_idx   = win_diff[plob_pkg::IDX_W-1:0];
                    n_fills = '0;
                    if (in_window && (i_order.quantity != '0)) begin
                        n_status = 1'b0;
                        n_state  = plob_pkg::ST_ADD_RD;
                    end else begin
                        n_status = 1'b1;
                        n_state  = plob_pkg::ST_DONE;
                    end
                end
            end
            plob_pkg::ST_ADD_RD: begin
                n_state = plob_pkg::ST_ADD_WR;
            end
            plob_pkg::ST_ADD_WR: begin
                alu_cmd = plob_pkg::ALU_ADD_SAT;
                alu_a   = r_buy ? r_bid_rd : r_ask_rd;
                if (r_buy) begin
                    bid_we    = 1'b1;
                    bid_waddr = r_idx;
                    bid_wdata = alu_res;
                    if (!r_bid_pres || (r_idx > r_best_bid)) begin
                        n_best_bid = r_idx;
                    end
                    n_bid_pres = 1'b1;
                end else begin
                    ask_we    = 1'b1;
                    ask_waddr = r_idx;
                    ask_wdata = alu_res;
                    if (!r_ask_pres || (r_idx < r_best_ask)) begin
                        n_best_ask = r_idx;
                    end
                    n_ask_pres = 1'b1;
                end
                n_state = plob_pkg::ST_CHECK;
            end
            plob_pkg::ST_CHECK: begin
                // The read addresses already point at both best levels.
                if (r_bid_pres && r_ask_pres && (r_best_bid >= r_best_ask)) begin
                    n_state = plob_pkg::ST_MATCH;
                end else begin
                    n_state = plob_pkg::ST_DONE;
                end
            end
            plob_pkg::ST_MATCH: begin
                // The smaller level is filled completely; the other keeps the difference.
                bid_we     = 1'b1;
                ask_we     = 1'b1;
                bid_wdata  = alu_lt ? '0 : alu_res;
                ask_wdata  = alu_lt ? alu_res : '0;
                n_trades   = r_trades + 1'b1;
                if (r_fills != plob_pkg::FILLS_MAX) begin
                    n_fills = r_fills + 1'b1;
                end
                n_scan_ask = !alu_lt;
                if (bid_empty) begin
                    n_state = plob_pkg::ST_BID_STEP;
                end else begin
                    n_state = plob_pkg::ST_ASK_STEP;
                end
            end
            plob_pkg::ST_BID_STEP: begin
                // Walk down from the emptied best bid to the next nonzero level.
                if (r_best_bid == '0) begin
                    n_bid_pres = 1'b0;
                    n_state    = r_scan_ask ? plob_pkg::ST_ASK_STEP : plob_pkg::ST_CHECK;
                end else begin
                    n_best_bid = r_best_bid - 1'b1;
                    n_state    = plob_pkg::ST_BID_RD;
                end
            end
            plob_pkg::ST_BID_RD: begin
                n_state = plob_pkg::ST_BID_CHK;
            end
            plob_pkg::ST_BID_CHK: begin
                if (r_bid_rd != '0) begin
                    n_state = r_scan_ask ? plob_pkg::ST_ASK_STEP : plob_pkg::ST_CHECK;
                end else begin
                    n_state = plob_pkg::ST_BID_STEP;
                end
            end
            plob_pkg::ST_ASK_STEP: begin
                // Walk up from the emptied best ask to the next nonzero level.
                if (r_best_ask == plob_pkg::IDX_LAST) begin
                    n_ask_pres = 1'b0;
                    n_state    = plob_pkg::ST_CHECK;
                end else begin
                    n_best_ask = r_best_ask + 1'b1;
                    n_state    = plob_pkg::ST_ASK_RD;
                end
            end
            plob_pkg::ST_ASK_RD: begin
                n_state = plob_pkg::ST_ASK_CHK;
            end
            plob_pkg::ST_ASK_CHK: begin
                if (r_ask_rd != '0) begin
                    n_state = plob_pkg::ST_CHECK;
                end else begin
                    n_state = plob_pkg::ST_ASK_STEP;
                end
            end
            plob_pkg::ST_DONE: begin
                // Wait here while an earlier result has not been taken.
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_fills   = r_fills;
                    n_o_trades  = r_trades;
                    n_o_bpres   = r_bid_pres;
                    n_o_bprice  = r_bid_pres ?
                                  (r_price_base + plob_pkg::PRICE_W'(r_best_bid)) : '0;
                    n_o_apres   = r_ask_pres;
                    n_o_aprice  = r_ask_pres ?
                                  (r_price_base + plob_pkg::PRICE_W'(r_best_ask)) : '0;
                    n_state     = plob_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plob_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the price-level order book matcher core.
// Needs plob_pkg, the channel interfaces and the core; it drives orders and checks each result
// against a behavioral model of the book kept inside this file.
module tb_top;
    localparam int PRICE_LEVELS   = plob_pkg::PRICE_LEVELS;
    localparam int LEVEL_QTY_BITS = plob_pkg::LEVEL_QTY_BITS;
    localparam int PRICE_W        = plob_pkg::PRICE_W;
    localparam int ORD_QTY_W      = plob_pkg::ORD_QTY_W;
    localparam int FILLS_W        = plob_pkg::FILLS_W;
    localparam int TRADES_W       = plob_pkg::TRADES_W;
    localparam int FILLS_MAX      = int'(plob_pkg::FILLS_MAX);

    localparam int  IDLE_LIMIT   = 200000;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  TAIL_CYCLES  = 64;
    localparam logic [PRICE_W-1:0] PRICE_TOP = '1;

    typedef enum logic {ROW_ORDER, ROW_BASE} t_row_kind;

    typedef struct packed {
        logic                status;
        logic [FILLS_W-1:0]  fills_in_order;
        logic [TRADES_W-1:0] total_trades;
        logic                bid_present;
        logic [PRICE_W-1:0]  best_bid_price;
        logic                ask_present;
        logic [PRICE_W-1:0]  best_ask_price;
    } t_book_report;

    typedef struct {
        t_row_kind            kind;
        logic                 buy_side;
        logic [PRICE_W-1:0]   price;
        logic [ORD_QTY_W-1:0] quantity;
        bit                   typed;
        t_book_report         report;
    } t_order_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [PRICE_W-1:0] i_cfg_wdata;

    plob_order_if  order_ch ();
    plob_result_if result_ch ();

    price_level_order_book_matcher_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_order     (order_ch),
        .o_result    (result_ch)
    );

    // Book model state.
    longint unsigned  bid_qty [PRICE_LEVELS];
    longint unsigned  ask_qty [PRICE_LEVELS];
    bit               bid_live [PRICE_LEVELS];
    bit               ask_live [PRICE_LEVELS];
    logic [TRADES_W-1:0] trades_so_far;
    logic [PRICE_W-1:0]  window_base;

    t_book_report pending_reports [$];
    t_order_row   directed_rows [$];

    int errors = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    function automatic bit top_bid(output int idx);
        for (int i = PRICE_LEVELS - 1; i >= 0; i--) begin
            if (bid_live[i]) begin
                idx = i;
                return 1'b1;
            end
        end
        idx = 0;
        return 1'b0;
    endfunction

    function automatic bit low_ask(output int idx);
        for (int i = 0; i < PRICE_LEVELS; i++) begin
            if (ask_live[i]) begin
                idx = i;
                return 1'b1;
            end
        end
        idx = 0;
        return 1'b0;
    endfunction

    // Adds one order to the book, crosses it out and reports the top of book.
    function automatic t_book_report match_order(logic buy, logic [PRICE_W-1:0] price,
                                                 logic [ORD_QTY_W-1:0] qty);
        t_book_report    rep;
        longint unsigned lvl_max;
        longint unsigned fill;
        int              bi;
        int              ai;
        int              idx;
        int              fills;
        bit              has_bid;
        bit              has_ask;
        lvl_max = (64'd1 << LEVEL_QTY_BITS) - 64'd1;
        fills   = 0;
        rep     = '0;
        rep.status = 1'b1;
        if (qty != 0 && price >= window_base && (price - window_base) < PRICE_LEVELS) begin
            idx = int'(price - window_base);
            if (buy) begin
                bid_qty[idx] = (qty > lvl_max - bid_qty[idx]) ? lvl_max : bid_qty[idx] + qty;
                bid_live[idx] = 1'b1;
            end else begin
                ask_qty[idx] = (qty > lvl_max - ask_qty[idx]) ? lvl_max : ask_qty[idx] + qty;
                ask_live[idx] = 1'b1;
            end
            rep.status = 1'b0;
            while (top_bid(bi) && low_ask(ai) && bi >= ai) begin
                fill = (bid_qty[bi] < ask_qty[ai]) ? bid_qty[bi] : ask_qty[ai];
                bid_qty[bi] -= fill;
                ask_qty[ai] -= fill;
                trades_so_far++;
                if (fills < FILLS_MAX) fills++;
                if (bid_qty[bi] == 0) bid_live[bi] = 1'b0;
                if (ask_qty[ai] == 0) ask_live[ai] = 1'b0;
            end
        end
        has_bid = top_bid(bi);
        has_ask = low_ask(ai);
        rep.fills_in_order = FILLS_W'(fills);
        rep.total_trades   = trades_so_far;
        rep.bid_present    = has_bid;
        rep.best_bid_price = has_bid ? PRICE_W'(window_base + bi) : '0;
        rep.ask_present    = has_ask;
        rep.best_ask_price = has_ask ? PRICE_W'(window_base + ai) : '0;
        return rep;
    endfunction

    // Result side: random back-pressure, checking and the watchdog.
    always @(posedge i_clk) begin
        t_book_report want;
        if ((order_ch.valid && order_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (result_ch.valid && result_ch.ready) begin
            if (pending_reports.size() == 0) begin
                $error("result with no order outstanding");
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (result_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, result_ch.status);
                    errors++;
                end
                if (result_ch.fills_in_order !== want.fills_in_order) begin
                    $error("fills_in_order: expected %0d, got %0d",
                           want.fills_in_order, result_ch.fills_in_order);
                    errors++;
                end
                if (result_ch.total_trades !== want.total_trades) begin
                    $error("total_trades: expected %0d, got %0d",
                           want.total_trades, result_ch.total_trades);
                    errors++;
                end
                if (result_ch.bid_present !== want.bid_present) begin
                    $error("bid_present: expected %0d, got %0d",
                           want.bid_present, result_ch.bid_present);
                    errors++;
                end
                if (result_ch.best_bid_price !== want.best_bid_price) begin
                    $error("best_bid_price: expected %0d, got %0d",
                           want.best_bid_price, result_ch.best_bid_price);
                    errors++;
                end
                if (result_ch.ask_present !== want.ask_present) begin
                    $error("ask_present: expected %0d, got %0d",
                           want.ask_present, result_ch.ask_present);
                    errors++;
                end
                if (result_ch.best_ask_price !== want.best_ask_price) begin
                    $error("best_ask_price: expected %0d, got %0d",
                           want.best_ask_price, result_ch.best_ask_price);
                    errors++;
                end
            end
        end
        result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Presents one order, holding valid high until the core takes it.
    task automatic send_order(logic buy, logic [PRICE_W-1:0] price, logic [ORD_QTY_W-1:0] qty,
                              bit typed, t_book_report typed_rep);
        t_book_report rep;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            order_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        order_ch.valid    <= 1'b1;
        order_ch.buy_side <= buy;
        order_ch.price    <= price;
        order_ch.quantity <= qty;
        @(posedge i_clk);
        while (!order_ch.ready) @(posedge i_clk);
        rep = match_order(buy, price, qty);
        pending_reports.insert(pending_reports.size(), typed ? typed_rep : rep);
    endtask

    task automatic drain_results();
        order_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Moves the price window; only done with nothing in flight.
    task automatic set_window_base(logic [PRICE_W-1:0] base);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_base = base;
    endtask

    task automatic add_row(t_row_kind kind, logic buy, logic [PRICE_W-1:0] price,
                           logic [ORD_QTY_W-1:0] qty, bit typed, t_book_report rep);
        t_order_row row;
        row.kind     = kind;
        row.buy_side = buy;
        row.price    = price;
        row.quantity = qty;
        row.typed    = typed;
        row.report   = rep;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Random order: mostly near the bottom of the window so the book keeps crossing, with
    // some deep prices, out-of-window prices and zero quantities mixed in.
    task automatic random_orders(int count);
        int                   pick;
        logic [PRICE_W-1:0]   price;
        logic [ORD_QTY_W-1:0] qty;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) price = PRICE_W'($urandom);
            else if (pick < 14) price = PRICE_W'(window_base + $urandom_range(0, PRICE_LEVELS));
            else price = PRICE_W'(window_base + $urandom_range(0, 31));
            pick = $urandom_range(0, 99);
            if (pick < 5) qty = '0;
            else if (pick < 30) qty = ORD_QTY_W'($urandom);
            else qty = ORD_QTY_W'($urandom_range(1, 200));
            send_order(1'($urandom), price, qty, 1'b0, '0);
        end
    endtask

    initial begin
        t_book_report r;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        order_ch.valid    = 1'b0;
        order_ch.buy_side = 1'b0;
        order_ch.price    = '0;
        order_ch.quantity = '0;
        tx_idle_pct     = 26;
        rx_idle_pct     = 76;
        trades_so_far   = '0;
        window_base     = '0;
        for (int i = 0; i < PRICE_LEVELS; i++) begin
            bid_qty[i] = 0; ask_qty[i] = 0; bid_live[i] = 0; ask_live[i] = 0;
        end

        // Directed rows. Typed results are those that follow directly from an empty book.
        r = '0; r.status = 1'b1;
        add_row(ROW_BASE, 0, '0, 0, 0, '0);
        add_row(ROW_ORDER, 1, '0, '0, 1, r);                  // zero quantity
        add_row(ROW_ORDER, 0, PRICE_W'(PRICE_LEVELS), 1, 1, r); // just past the window
        add_row(ROW_ORDER, 1, PRICE_TOP, '1, 1, r);           // top price, far out
        r = '0; r.bid_present = 1'b1;
        add_row(ROW_ORDER, 1, '0, '1, 1, r);                  // lowest level, full quantity
        r.ask_present = 1'b1; r.best_ask_price = PRICE_W'(PRICE_LEVELS - 1);
        add_row(ROW_ORDER, 0, PRICE_W'(PRICE_LEVELS - 1), 1, 1, r);
        r.bid_present = 1'b0; r.fills_in_order = 1; r.total_trades = 1;
        add_row(ROW_ORDER, 0, '0, '1, 1, r);                  // exact cross empties both
        add_row(ROW_ORDER, 1, PRICE_W'(PRICE_LEVELS - 1), 3, 0, '0);
        add_row(ROW_ORDER, 0, 20'd5, 100, 0, '0);
        add_row(ROW_ORDER, 0, 20'd7, 30, 0, '0);
        add_row(ROW_ORDER, 1, 20'd10, 40, 0, '0);             // partly fills the ask level at 5
        add_row(ROW_ORDER, 1, 20'd10, 200, 0, '0);
        add_row(ROW_ORDER, 0, 20'd2, 1, 0, '0);
        add_row(ROW_ORDER, 1, 20'd3, 16'h5555, 0, '0);
        add_row(ROW_ORDER, 0, 20'd1, 16'hAAAA, 0, '0);
        add_row(ROW_BASE, 0, PRICE_TOP, 0, 0, '0);            // window holds one tick only
        add_row(ROW_ORDER, 1, PRICE_TOP, 7, 0, '0);
        add_row(ROW_ORDER, 0, PRICE_TOP - 1, 1, 0, '0);       // just below the window
        add_row(ROW_ORDER, 0, PRICE_TOP, 3, 0, '0);
        add_row(ROW_ORDER, 0, PRICE_TOP, 9, 0, '0);
        add_row(ROW_BASE, 0, 20'd1000, 0, 0, '0);
        add_row(ROW_ORDER, 1, 20'd999, 5, 0, '0);
        add_row(ROW_ORDER, 1, 20'd1000, 5, 0, '0);
        add_row(ROW_ORDER, 0, PRICE_W'(1000 + PRICE_LEVELS - 1), 5, 0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_BASE) begin
                set_window_base(directed_rows[k].price);
            end else begin
                send_order(directed_rows[k].buy_side, directed_rows[k].price,
                           directed_rows[k].quantity, directed_rows[k].typed,
                           directed_rows[k].report);
            end
        end

        // Fast sender, lazy receiver.
        set_window_base(20'd0);
        random_orders(530);

        // Slow sender, busy receiver; the sender also waits once for the book to settle.
        set_window_base(20'd524288);
        tx_idle_pct = 76;
        rx_idle_pct = 26;
        random_orders(260);
        drain_results();
        random_orders(260);

        // No idling on either side, window pushed against the top of the price range.
        set_window_base(PRICE_TOP - 20'd40);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_orders(540);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
